### rtl/rapl_pkg.sv
// Package for the request argument list parser: phase and status codes, limits.
`timescale 1ns / 1ps

package rapl_pkg;

  // Default upper bound on the announced argument count
  localparam int unsigned ARG_LIMIT_DEF = 16;

  // Width of each length-prefix field in bytes is fixed at four
  localparam int unsigned FIELD_BYTES = 4;

  // Parser phase
  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  // Frame status reported on the final byte
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_TRUNC     = 2'd2,
    ST_TRAIL     = 2'd3
  } status_t;

endpackage

### rtl/request_arg_list_parser.sv
// Top level of the length-prefixed request argument list parser.
//
// Usage: the input channel (in_valid / in_ready) carries one payload byte per
// transfer with in_frame_last on the final byte of a payload. The payload is a
// 4-byte big-endian argument count (1 to ARG_LIMIT), then per argument a
// 4-byte big-endian length and that many data bytes. Every input transfer
// yields exactly one result transfer on the out_ channel: data bytes tagged
// with their argument index, an end mark with the argument length, and on the
// final byte frame_done with the status and the announced count.
// The result is valid in the cycle after the input transfer. Throughput is
// one byte per cycle unless stalled; the per-byte update is a byte shift, a
// length down-counter and a small argument counter, all resolved in the cycle
// of the transfer. The result sits in a single output register; in_ready stays
// high while that register is empty or is being drained in the same cycle, so
// a stalled receiver holds off the input after one result is pending.
// Synchronous reset returns the parser to reading the argument count and
// empties the output register; the final byte of each payload does the same
// for the parser state.
`timescale 1ns / 1ps

module request_arg_list_parser #(
  parameter int unsigned ARG_LIMIT = rapl_pkg::ARG_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_frame_last,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_data_valid,
  output logic [7:0]  out_arg_byte,
  output logic [3:0]  out_arg_index,
  output logic        out_arg_end,
  output logic [31:0] out_arg_length,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_status,
  output logic [4:0]  out_arg_count
);

  // Counter width holds 0..ARG_LIMIT
  localparam int unsigned CW = $clog2(ARG_LIMIT + 1);
  localparam int unsigned SW = (rapl_pkg::FIELD_BYTES - 1) * 8;
  localparam int unsigned PW = $clog2(rapl_pkg::FIELD_BYTES);

  // Parser state
  rapl_pkg::phase_t  phase_r,   phase_stp,   phase_nxt;
  rapl_pkg::status_t err_r,     err_stp,     err_nxt;
  logic [PW-1:0]     pos_r,     pos_stp,     pos_nxt;
  logic [SW-1:0]     shift_r,   shift_stp,   shift_nxt;
  logic [CW-1:0]     ann_r,     ann_stp,     ann_nxt;
  logic [CW-1:0]     cur_r,     cur_stp,     cur_nxt;
  logic [31:0]       left_r,    left_stp,    left_nxt;
  logic [31:0]       len_r,     len_stp,     len_nxt;

  // Output register
  logic        out_valid_r;
  logic        dv_r,  dv_nxt;
  logic [7:0]  ab_r,  ab_nxt;
  logic [3:0]  ai_r,  ai_nxt;
  logic        ae_r,  ae_nxt;
  logic [31:0] al_r,  al_nxt;
  logic        fd_r,  fd_nxt;
  logic [1:0]  fs_r,  fs_nxt;
  logic [4:0]  ac_r,  ac_nxt;

  logic          in_xfer;
  logic          fld_done;
  logic [31:0]   fld_val;
  logic          cnt_bad;
  logic [CW:0]   cur_inc;
  logic          arg_last;
  logic          parsing;
  logic [CW+3:0] cur_ext;
  logic [CW+4:0] ann_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Field assembly and shared decodes
  assign fld_done = (pos_r == PW'(rapl_pkg::FIELD_BYTES - 1));
  assign fld_val  = {shift_r, in_payload_byte};
  assign cnt_bad  = (fld_val == 32'd0) || (fld_val > 32'(ARG_LIMIT));
  assign cur_inc  = {1'b0, cur_r} + (CW + 1)'(1);
  assign arg_last = (cur_inc >= {1'b0, ann_r});
  assign parsing  = (err_r == rapl_pkg::ST_OK);
  assign cur_ext  = {4'd0, cur_r};

  // Next state for one byte, before the end-of-frame return to reset
  always_comb begin
    phase_stp = phase_r;
    err_stp   = err_r;
    pos_stp   = pos_r;
    shift_stp = shift_r;
    ann_stp   = ann_r;
    cur_stp   = cur_r;
    left_stp  = left_r;
    len_stp   = len_r;
    if (parsing) begin
      unique case (phase_r)
        rapl_pkg::PH_COUNT: begin
          pos_stp   = pos_r + PW'(1);
          shift_stp = fld_val[SW-1:0];
          if (fld_done) begin
            if (cnt_bad) begin
              err_stp = rapl_pkg::ST_BAD_COUNT;
            end else begin
              ann_stp   = fld_val[CW-1:0];
              cur_stp   = '0;
              phase_stp = rapl_pkg::PH_LEN;
            end
          end
        end
        rapl_pkg::PH_LEN: begin
          pos_stp   = pos_r + PW'(1);
          shift_stp = fld_val[SW-1:0];
          if (fld_done) begin
            len_stp = fld_val;
            if (fld_val == 32'd0) begin
              cur_stp   = cur_inc[CW-1:0];
              phase_stp = arg_last ? rapl_pkg::PH_DONE : rapl_pkg::PH_LEN;
            end else begin
              left_stp  = fld_val;
              phase_stp = rapl_pkg::PH_DATA;
            end
          end
        end
        rapl_pkg::PH_DATA: begin
          left_stp = left_r - 32'd1;
          if (left_r == 32'd1) begin
            cur_stp   = cur_inc[CW-1:0];
            phase_stp = arg_last ? rapl_pkg::PH_DONE : rapl_pkg::PH_LEN;
          end
        end
        rapl_pkg::PH_DONE: begin
          err_stp = rapl_pkg::ST_TRAIL;
        end
        default: begin
          err_stp = err_r;
        end
      endcase
    end
  end

  // Final byte returns the parser to its reset state
  always_comb begin
    if (in_frame_last) begin
      phase_nxt = rapl_pkg::PH_COUNT;
      err_nxt   = rapl_pkg::ST_OK;
      pos_nxt   = '0;
      shift_nxt = '0;
      ann_nxt   = '0;
      cur_nxt   = '0;
      left_nxt  = '0;
      len_nxt   = '0;
    end else begin
      phase_nxt = phase_stp;
      err_nxt   = err_stp;
      pos_nxt   = pos_stp;
      shift_nxt = shift_stp;
      ann_nxt   = ann_stp;
      cur_nxt   = cur_stp;
      left_nxt  = left_stp;
      len_nxt   = len_stp;
    end
  end

  // Result fields for this byte
  assign ann_ext = {5'd0, ann_stp};
  always_comb begin
    dv_nxt = 1'b0;
    ab_nxt = 8'd0;
    ai_nxt = 4'd0;
    ae_nxt = 1'b0;
    al_nxt = 32'd0;
    fd_nxt = 1'b0;
    fs_nxt = rapl_pkg::ST_OK;
    ac_nxt = 5'd0;
    if (parsing && (phase_r == rapl_pkg::PH_DATA)) begin
      dv_nxt = 1'b1;
      ab_nxt = in_payload_byte;
      ai_nxt = cur_ext[3:0];
      if (left_r == 32'd1) begin
        ae_nxt = 1'b1;
        al_nxt = len_r;
      end
    end else if (parsing && (phase_r == rapl_pkg::PH_LEN) && fld_done &&
                 (fld_val == 32'd0)) begin
      ai_nxt = cur_ext[3:0];
      ae_nxt = 1'b1;
    end
    if (in_frame_last) begin
      fd_nxt = 1'b1;
      ac_nxt = ann_ext[4:0];
      if (err_stp != rapl_pkg::ST_OK) begin
        fs_nxt = err_stp;
      end else if (phase_stp != rapl_pkg::PH_DONE) begin
        fs_nxt = rapl_pkg::ST_TRUNC;
      end else begin
        fs_nxt = rapl_pkg::ST_OK;
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rapl_pkg::PH_COUNT;
      err_r   <= rapl_pkg::ST_OK;
      pos_r   <= '0;
      shift_r <= '0;
      ann_r   <= '0;
      cur_r   <= '0;
      left_r  <= '0;
      len_r   <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      ann_r   <= ann_nxt;
      cur_r   <= cur_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dv_r <= dv_nxt;
      ab_r <= ab_nxt;
      ai_r <= ai_nxt;
      ae_r <= ae_nxt;
      al_r <= al_nxt;
      fd_r <= fd_nxt;
      fs_r <= fs_nxt;
      ac_r <= ac_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_valid   = dv_r;
  assign out_arg_byte     = ab_r;
  assign out_arg_index    = ai_r;
  assign out_arg_end      = ae_r;
  assign out_arg_length   = al_r;
  assign out_frame_done   = fd_r;
  assign out_frame_status = fs_r;
  assign out_arg_count    = ac_r;

endmodule

### rtl/rapl_checker.sv
// Port-level checker for the request argument list parser, bound to the top level.
`timescale 1ns / 1ps

module rapl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_payload_byte,
  input logic        in_frame_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_data_valid,
  input logic [7:0]  out_arg_byte,
  input logic [3:0]  out_arg_index,
  input logic        out_arg_end,
  input logic [31:0] out_arg_length,
  input logic        out_frame_done,
  input logic [1:0]  out_frame_status,
  input logic [4:0]  out_arg_count
);

  // Every input transfer produces a result in the next cycle
  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("input transfer without result");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // An argument that ends on a data byte has nonzero length
  a_data_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_valid && out_arg_end) |-> (out_arg_length != 32'd0))
    else $error("data byte ends argument with zero length");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_data_valid) && $stable(out_arg_byte) &&
       $stable(out_arg_index) && $stable(out_arg_end) &&
       $stable(out_arg_length) && $stable(out_frame_done) &&
       $stable(out_frame_status) && $stable(out_arg_count)))
    else $error("stalled result changed");

endmodule

bind request_arg_list_parser rapl_checker u_rapl_checker (.*);

### dv/tb.sv
// Testbench for the request argument list parser: payload bytes in, every result checked.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ARG_LIMIT    = rapl_pkg::ARG_LIMIT_DEF;
  localparam int unsigned RANDOM_BYTES = 640;
  localparam int unsigned STREAM_BYTES = 80;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  // One result transfer, fields in port order
  typedef struct packed {
    logic              data_valid;
    logic [7:0]        arg_byte;
    logic [3:0]        arg_index;
    logic              arg_end;
    logic [31:0]       arg_length;
    logic              frame_done;
    rapl_pkg::status_t frame_status;
    logic [4:0]        arg_count;
  } arg_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_payload_byte;
  logic        in_frame_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_data_valid;
  logic [7:0]  out_arg_byte;
  logic [3:0]  out_arg_index;
  logic        out_arg_end;
  logic [31:0] out_arg_length;
  logic        out_frame_done;
  logic [1:0]  out_frame_status;
  logic [4:0]  out_arg_count;

  // Parser state as the testbench tracks it
  rapl_pkg::phase_t  p_phase;
  logic [1:0]        p_pos;
  logic [31:0]       p_acc;
  logic [31:0]       p_nargs;
  logic [31:0]       p_arg;
  logic [31:0]       p_left;
  logic [31:0]       p_len;
  rapl_pkg::status_t p_err;

  arg_result_t expected_results[$];
  logic [7:0]  frame_q[$];

  bit          idle_on;
  bit          hold_start;
  int unsigned idle_cycles;
  int unsigned failures;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned bytes_accepted;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned data_seen;
  int unsigned ends_seen;
  int unsigned status_seen[4];

  request_arg_list_parser #(
    .ARG_LIMIT(ARG_LIMIT)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_payload_byte  (in_payload_byte),
    .in_frame_last    (in_frame_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_valid   (out_data_valid),
    .out_arg_byte     (out_arg_byte),
    .out_arg_index    (out_arg_index),
    .out_arg_end      (out_arg_end),
    .out_arg_length   (out_arg_length),
    .out_frame_done   (out_frame_done),
    .out_frame_status (out_frame_status),
    .out_arg_count    (out_arg_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    p_phase = rapl_pkg::PH_COUNT;
    p_pos   = '0;
    p_acc   = '0;
    p_nargs = '0;
    p_arg   = '0;
    p_left  = '0;
    p_len   = '0;
    p_err   = rapl_pkg::ST_OK;
  endfunction

  function automatic void advance_arg();
    p_arg   = p_arg + 1;
    p_phase = (p_arg >= p_nargs) ? rapl_pkg::PH_DONE : rapl_pkg::PH_LEN;
  endfunction

  // Expected result for one accepted payload byte; updates the tracked state
  function automatic arg_result_t parse_byte(input logic [7:0] b, input logic last);
    arg_result_t r;
    logic [31:0] field;
    logic        field_full;
    r          = '0;
    field      = '0;
    field_full = 1'b0;
    if (p_err == rapl_pkg::ST_OK) begin
      // count and length fields are shifted in big-endian
      if (p_phase == rapl_pkg::PH_COUNT || p_phase == rapl_pkg::PH_LEN) begin
        p_acc      = {p_acc[23:0], b};
        p_pos      = p_pos + 2'd1;
        field_full = (p_pos == 2'd0);
        field      = p_acc;
        if (field_full) p_acc = '0;
      end
      case (p_phase)
        rapl_pkg::PH_COUNT: begin
          if (field_full) begin
            if (field == 0 || field > ARG_LIMIT) begin
              p_err = rapl_pkg::ST_BAD_COUNT;
            end else begin
              p_nargs = field;
              p_arg   = '0;
              p_phase = rapl_pkg::PH_LEN;
            end
          end
        end
        rapl_pkg::PH_LEN: begin
          if (field_full) begin
            p_len = field;
            if (field == 0) begin
              // empty argument ends on its last length byte
              r.arg_index = p_arg[3:0];
              r.arg_end   = 1'b1;
              advance_arg();
            end else begin
              p_left  = field;
              p_phase = rapl_pkg::PH_DATA;
            end
          end
        end
        rapl_pkg::PH_DATA: begin
          r.data_valid = 1'b1;
          r.arg_byte   = b;
          r.arg_index  = p_arg[3:0];
          p_left       = p_left - 1;
          if (p_left == 0) begin
            r.arg_end    = 1'b1;
            r.arg_length = p_len;
            advance_arg();
          end
        end
        default: p_err = rapl_pkg::ST_TRAIL;
      endcase
    end
    if (last) begin
      r.frame_done = 1'b1;
      if (p_err != rapl_pkg::ST_OK)         r.frame_status = p_err;
      else if (p_phase != rapl_pkg::PH_DONE) r.frame_status = rapl_pkg::ST_TRUNC;
      else                                   r.frame_status = rapl_pkg::ST_OK;
      r.arg_count = p_nargs[4:0];
      clear_parser();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check result transfers first, then queue the prediction
  // for an input transfer at the same edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    arg_result_t got;
    arg_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_data_valid, out_arg_byte, out_arg_index, out_arg_end, out_arg_length,
             out_frame_done, out_frame_status, out_arg_count};
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: result transfer with nothing expected", $time);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.data_valid) data_seen++;
        if (want.arg_end)    ends_seen++;
        if (want.frame_done) status_seen[want.frame_status]++;
        if (got !== want) begin
          failures++;
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display({"%0t: mismatch exp dv=%0b byte=%02h idx=%0d end=%0b len=%0d",
                      " done=%0b st=%0d cnt=%0d"},
                     $time, want.data_valid, want.arg_byte, want.arg_index, want.arg_end,
                     want.arg_length, want.frame_done, want.frame_status, want.arg_count);
            $display({"%0t:          got dv=%0b byte=%02h idx=%0d end=%0b len=%0d",
                      " done=%0b st=%0d cnt=%0d"},
                     $time, got.data_valid, got.arg_byte, got.arg_index, got.arg_end,
                     got.arg_length, got.frame_done, got.frame_status, got.arg_count);
          end
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(parse_byte(in_payload_byte, in_frame_last));
      bytes_accepted++;
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_on || ($urandom_range(99) >= 10);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte and wait for its transfer; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_frame_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
    bytes_sent += frame_q.size();
    frames_sent++;
  endtask

  task automatic push_word(input logic [31:0] w);
    frame_q.push_back(w[31:24]);
    frame_q.push_back(w[23:16]);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
  endtask

  task automatic push_arg(input logic [31:0] len);
    push_word(len);
    repeat (len) frame_q.push_back(8'($urandom_range(255)));
  endtask

  // Mostly short arguments, a fair share empty, now and then a longer one
  function automatic logic [31:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 0;
    if (r < 85) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  task automatic build_good_frame();
    int unsigned nargs;
    nargs = ($urandom_range(9) == 0) ? ARG_LIMIT : $urandom_range(1, 4);
    push_word(nargs);
    repeat (nargs) push_arg(pick_len());
  endtask

  // Well-formed frames most of the time, the rest broken in one of several ways
  task automatic build_random_frame();
    int unsigned kind;
    int unsigned cut;
    logic [31:0] bad;
    frame_q.delete();
    kind = $urandom_range(99);
    if (kind >= 95) begin
      // noise
      repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(255)));
    end else if (kind >= 88) begin
      // count out of range, then bytes that must be ignored
      case ($urandom_range(2))
        0:       bad = 0;
        1:       bad = ARG_LIMIT + 1 + $urandom_range(300);
        default: bad = $urandom | 32'h8000_0000;
      endcase
      push_word(bad);
      repeat ($urandom_range(5)) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      build_good_frame();
      if (kind >= 80) begin
        // trailing bytes
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(255)));
      end else if (kind >= 70) begin
        // ends early
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    // final byte while the count is still open
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    // all-ones count, then a byte that is ignored
    frame_q.delete();
    push_word(32'hFFFF_FFFF);
    frame_q.push_back(8'h5A);
    send_frame();
    // empty argument, then a stray byte
    frame_q.delete();
    push_word(1);
    push_word(0);
    frame_q.push_back(8'h00);
    send_frame();
    // one argument with a single all-ones data byte
    frame_q.delete();
    push_word(1);
    push_word(1);
    frame_q.push_back(8'hFF);
    send_frame();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      build_random_frame();
      send_frame();
    end
  endtask

  // Both sides at full rate
  task automatic test_full_rate();
    int unsigned start;
    start   = bytes_sent;
    idle_on = 1'b0;
    while (bytes_sent - start < STREAM_BYTES) begin
      frame_q.delete();
      build_good_frame();
      send_frame();
    end
    idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_receiver_hold();
    hold_start = 1'b1;
    frame_q.delete();
    push_word(2);
    push_arg(12);
    push_arg(9);
    send_frame();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_payload_byte = '0;
    in_frame_last   = 1'b0;
    idle_on         = 1'b1;
    hold_start      = 1'b0;
    clear_parser();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_frames();
    test_full_rate();
    test_receiver_hold();
    in_valid <= 1'b0;

    // drain, then wait for anything unexpected
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d payloads, %0d bytes, %0d results (%0d data bytes, %0d arg ends)",
             frames_sent, bytes_accepted, results_checked, data_seen, ends_seen);
    $display("Status ok %0d, bad count %0d, truncated %0d, trailing %0d; %0d errors",
             status_seen[rapl_pkg::ST_OK], status_seen[rapl_pkg::ST_BAD_COUNT],
             status_seen[rapl_pkg::ST_TRUNC], status_seen[rapl_pkg::ST_TRAIL], failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### request_arg_list_parser.f
rtl/rapl_pkg.sv
rtl/request_arg_list_parser.sv
rtl/rapl_checker.sv
dv/tb.sv
